@@ rtl/core/signed_int_to_padded_decimal_text_defines.svh @@
// Assertion macros shared by the decimal text formatter modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SIGNED_INT_TO_PADDED_DECIMAL_TEXT_DEFINES_SVH
`define SIGNED_INT_TO_PADDED_DECIMAL_TEXT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SIDT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SIDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sidt_pkg.sv @@
// Shared constants, register indexes and the converter-to-emitter word type
// for the decimal text formatter. Depends on nothing.
package sidt_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 7;
  localparam int FW_W       = 6;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int NDIG_W     = 4;
  localparam int CFG_IDX_W  = 2;

  localparam int DEF_MAX_FIELD_WIDTH = 32;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;

  localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGN_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_FILL   = 2'd2;

  localparam logic [FW_W-1:0] RST_FIELD_WIDTH = 6'd5;
  localparam logic            RST_SIGN_ENABLE = 1'b0;
  localparam logic            RST_ZERO_FILL   = 1'b1;

  typedef struct packed {
    logic [BCD_W-1:0]  bcd;
    logic [NDIG_W-1:0] ndig;
    logic              negative;
  } bcd_word_t;

endpackage

@@ rtl/core/signed_int_to_padded_decimal_text.sv @@
// A word is converted by the serial BCD shifter, trimmed of leading zeros and handed over,
// and its characters are then presented through the registered output stage.
// Throughput: one character per cycle while a word is held and out_ready is high; the next
// word is converted while the previous one is emitted.
// The serial BCD shifter and the one-character output register set this rate.
// Synchronous reset clears control state and loads width 5, sign off, zero fill on.
module signed_int_to_padded_decimal_text #(
  parameter int MAX_FIELD_WIDTH = sidt_pkg::DEF_MAX_FIELD_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [sidt_pkg::VALUE_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sidt_pkg::CHAR_W-1:0]        char_code,
  output logic                               last_char,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sidt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sidt_pkg::FW_W-1:0]          cfg_data
);
  import sidt_pkg::*;

  logic [FW_W-1:0] field_width;
  logic            sign_enable;
  logic            zero_fill;
  logic            word_valid;
  logic            word_ready;
  bcd_word_t       word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_width <= RST_FIELD_WIDTH;
      sign_enable <= RST_SIGN_ENABLE;
      zero_fill   <= RST_ZERO_FILL;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FIELD_WIDTH: field_width <= cfg_data;
        REG_SIGN_ENABLE: sign_enable <= cfg_data[0];
        REG_ZERO_FILL:   zero_fill   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sidt_bcd_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word       (word)
  );

  sidt_emit #(
    .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .word_valid  (word_valid),
    .word_ready  (word_ready),
    .word        (word),
    .field_width (field_width),
    .sign_enable (sign_enable),
    .zero_fill   (zero_fill),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .char_code   (char_code),
    .last_char   (last_char)
  );
endmodule

@@ rtl/core/sidt_bcd_conv.sv @@
// Bit-serial binary to BCD converter with leading-zero trimming.
// Depends on sidt_pkg and the assertion macro header.
`include "signed_int_to_padded_decimal_text_defines.svh"

module sidt_bcd_conv (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [sidt_pkg::VALUE_W-1:0] value,
  output logic                               word_valid,
  input  logic                               word_ready,
  output sidt_pkg::bcd_word_t                word
);
  import sidt_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_TRIM  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]         state;
  logic [VALUE_W-1:0] mag;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_adj;
  logic               negative;
  logic [4:0]         bit_cnt;
  logic [NDIG_W-1:0]  ndig;
  logic [VALUE_W-1:0] raw;

  assign raw = value;

  always_comb begin
    logic [3:0] d;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = bcd[4*i +: 4];
      bcd_adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            negative <= raw[VALUE_W-1];
            mag      <= raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
            bcd      <= '0;
            bit_cnt  <= '0;
            state    <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          bcd     <= {bcd_adj[BCD_W-2:0], mag[VALUE_W-1]};
          mag     <= {mag[VALUE_W-2:0], 1'b0};
          bit_cnt <= bit_cnt + 5'd1;
          if (bit_cnt == 5'd31) begin
            ndig  <= NDIG_W'(NUM_DIGITS);
            state <= ST_TRIM;
          end
        end
        ST_TRIM: begin
          if (bcd[BCD_W-1 -: 4] == 4'd0 && ndig != 4'd1) begin
            bcd  <= {bcd[BCD_W-5:0], 4'd0};
            ndig <= ndig - 4'd1;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (word_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign in_ready      = (state == ST_IDLE);
  assign word_valid    = (state == ST_DONE);
  assign word.bcd      = bcd;
  assign word.ndig     = ndig;
  assign word.negative = negative;

  `SIDT_ASSERT_NEXT(a_accept_starts_shift, clk, rst, in_valid && in_ready,
    state == ST_SHIFT, "accepted word did not start the shift phase")
  `SIDT_ASSERT_NOW(a_done_trimmed, clk, rst, state == ST_DONE,
    bcd[BCD_W-1 -: 4] != 4'd0 || ndig == 4'd1, "leading zero left in finished word")
  `SIDT_ASSERT_NOW(a_ndig_range, clk, rst, state == ST_TRIM || state == ST_DONE,
    ndig != 4'd0 && ndig <= NDIG_W'(NUM_DIGITS), "digit count out of range")
endmodule

@@ rtl/core/sidt_emit.sv @@
// Character sequencer: optional sign, padding, then BCD digits one per character,
// through a registered output stage. Depends on sidt_pkg and the macro header.
`include "signed_int_to_padded_decimal_text_defines.svh"

module sidt_emit #(
  parameter int MAX_FIELD_WIDTH = sidt_pkg::DEF_MAX_FIELD_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        word_valid,
  output logic                        word_ready,
  input  sidt_pkg::bcd_word_t         word,
  input  logic [sidt_pkg::FW_W-1:0]   field_width,
  input  logic                        sign_enable,
  input  logic                        zero_fill,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sidt_pkg::CHAR_W-1:0] char_code,
  output logic                        last_char
);
  import sidt_pkg::*;

  localparam int PW = $clog2(MAX_FIELD_WIDTH + 1);

  localparam logic [1:0] PH_SIGN  = 2'd0;
  localparam logic [1:0] PH_PAD   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  logic              busy;
  logic [1:0]        phase;
  logic [PW-1:0]     pad_cnt;
  logic [NDIG_W-1:0] dig_cnt;
  logic [BCD_W-1:0]  bcd;
  logic              negative;
  logic              fill_zero;
  logic              take;
  logic              advance;
  logic [6:0]        width_sat;
  logic [6:0]        pad_wide;
  logic [PW-1:0]     pad_new;

  always_comb begin
    width_sat = ({1'b0, field_width} > 7'(MAX_FIELD_WIDTH)) ?
                7'(MAX_FIELD_WIDTH) : {1'b0, field_width};
    pad_wide  = (width_sat > {3'd0, word.ndig}) ? width_sat - {3'd0, word.ndig} : 7'd0;
    pad_new   = pad_wide[PW-1:0];
  end

  assign word_ready = !busy;
  assign take       = word_valid && !busy;
  assign advance    = busy && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase     <= PH_SIGN;
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && !out_ready);
      if (take) begin
        busy      <= 1'b1;
        bcd       <= word.bcd;
        dig_cnt   <= word.ndig;
        negative  <= word.negative;
        fill_zero <= zero_fill;
        pad_cnt   <= pad_new;
        if (sign_enable) begin
          phase <= PH_SIGN;
        end else if (pad_new != '0) begin
          phase <= PH_PAD;
        end else begin
          phase <= PH_DIGIT;
        end
      end else if (advance) begin
        case (phase)
          PH_SIGN: begin
            char_code <= negative ? CH_MINUS : CH_SPACE;
            last_char <= 1'b0;
            phase     <= (pad_cnt != '0) ? PH_PAD : PH_DIGIT;
          end
          PH_PAD: begin
            char_code <= fill_zero ? CH_ZERO : CH_SPACE;
            last_char <= 1'b0;
            pad_cnt   <= pad_cnt - PW'(1);
            if (pad_cnt == PW'(1)) begin
              phase <= PH_DIGIT;
            end
          end
          default: begin
            char_code <= CH_ZERO + {3'd0, bcd[BCD_W-1 -: 4]};
            last_char <= (dig_cnt == 4'd1);
            bcd       <= {bcd[BCD_W-5:0], 4'd0};
            dig_cnt   <= dig_cnt - 4'd1;
            if (dig_cnt == 4'd1) begin
              busy <= 1'b0;
            end
          end
        endcase
      end
    end
  end

  `SIDT_ASSERT_NOW(a_pad_nonzero, clk, rst, busy && phase == PH_PAD,
    pad_cnt != '0, "pad phase entered with nothing to pad")
  `SIDT_ASSERT_NOW(a_digits_left, clk, rst, busy && phase == PH_DIGIT,
    dig_cnt != 4'd0, "digit phase with no digits left")
  `SIDT_ASSERT_NEXT(a_last_frees, clk, rst,
    advance && phase == PH_DIGIT && dig_cnt == 4'd1,
    !busy && out_valid && last_char, "final digit did not end the word")
endmodule
